// ===== rtl/core/twd_pkg.sv =====
// Shared types and constants for the touch wheel position decoder.
// No dependencies; imported by twd_decode and the top level.
package twd_pkg;

    localparam int PAD_COUNT = 4;
    localparam int PAD_IDX_W = 2;
    localparam int REG_W     = 10;
    localparam int POS_W     = 3;
    localparam int STEP_W    = 4;

    localparam logic [REG_W-1:0] THRESH_RESET = REG_W'(30);
    localparam logic [POS_W-1:0] WRAP_POS     = POS_W'(7);

    typedef enum logic
    {
        CFG_TOUCH_THRESHOLD = 1'b0,
        CFG_PAIR_THRESHOLD  = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        logic             found;
        logic [POS_W-1:0] pos;
    } twd_hit_t;

endpackage

// ===== rtl/core/touch_wheel_position_decoder_unit.sv =====
// Top level of the touch wheel position decoder: input register, decode, result register.
// Depends on twd_pkg and twd_decode.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------
//  scan     | scan_valid / scan_ready    | pad_top, pad_right, pad_bottom, pad_left
//  result   | result_valid / result_ready| touch_valid, position, step
//  config   | cfg_we                     | cfg_index, cfg_data
//
// One scan per cycle while results are taken; via input register, then result register.
// Decode of a scan is a single pass of compare logic between the two registers.
// Reset clears both thresholds to 30 and the last-touch state to "no touch".
// A stalled result holds the result register; the input register still takes
// one more scan, then scan_ready drops until the result is taken.
module touch_wheel_position_decoder_unit
    import twd_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     scan_valid,
    output logic                     scan_ready,
    input  logic [SAMPLE_BITS-1:0]   pad_top,
    input  logic [SAMPLE_BITS-1:0]   pad_right,
    input  logic [SAMPLE_BITS-1:0]   pad_bottom,
    input  logic [SAMPLE_BITS-1:0]   pad_left,

    output logic                     result_valid,
    input  logic                     result_ready,
    output logic                     touch_valid,
    output logic [POS_W-1:0]         position,
    output logic signed [STEP_W-1:0] step,

    input  logic                     cfg_we,
    input  cfg_index_t               cfg_index,
    input  logic [REG_W-1:0]         cfg_data
);

    logic [REG_W-1:0]       touch_thr_reg;
    logic [REG_W-1:0]       pair_thr_reg;

    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] pad_reg [PAD_COUNT];

    logic                   out_valid_reg;
    logic                   touch_valid_reg;
    logic [POS_W-1:0]       position_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [STEP_W-1:0]      step_next;

    logic [POS_W-1:0]       last_pos_reg;
    logic                   last_valid_reg;

    logic                   scan_take;
    logic                   advance;
    twd_hit_t               hit;

    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign scan_ready = !in_valid_reg || advance;
    assign scan_take  = scan_valid && scan_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touch_thr_reg <= THRESH_RESET;
            pair_thr_reg  <= THRESH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TOUCH_THRESHOLD: touch_thr_reg <= cfg_data;
                CFG_PAIR_THRESHOLD:  pair_thr_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (scan_ready)
        begin
            in_valid_reg <= scan_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_take)
        begin
            pad_reg[0] <= pad_top;
            pad_reg[1] <= pad_right;
            pad_reg[2] <= pad_bottom;
            pad_reg[3] <= pad_left;
        end
    end

    twd_decode #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_decode (
        .pad             (pad_reg),
        .touch_threshold (touch_thr_reg),
        .pair_threshold  (pair_thr_reg),
        .hit             (hit)
    );

    // no wrap: plain difference, two's complement in 4 bits
    assign step_next = (hit.found && last_valid_reg)
                     ? ({1'b0, hit.pos} - {1'b0, last_pos_reg}) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            last_pos_reg   <= '0;
            last_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                last_valid_reg <= hit.found;
                if (hit.found)
                begin
                    last_pos_reg <= hit.pos;
                end
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            touch_valid_reg <= hit.found;
            position_reg    <= hit.pos;
            step_reg        <= step_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign touch_valid  = touch_valid_reg;
    assign position     = position_reg;
    assign step         = signed'(step_reg);

endmodule

// ===== rtl/core/twd_decode.sv =====
// Combinational decode of one scan: touched pads, strongest pad, neighbor, position.
// Depends on twd_pkg.
module twd_decode
    import twd_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
)
(
    input  logic [SAMPLE_BITS-1:0] pad [PAD_COUNT],
    input  logic [REG_W-1:0]       touch_threshold,
    input  logic [REG_W-1:0]       pair_threshold,
    output twd_hit_t               hit
);

    localparam int SUM_W = ((SAMPLE_BITS > REG_W) ? SAMPLE_BITS : REG_W) + 1;

    logic [SAMPLE_BITS-1:0] ref_level;
    logic [PAD_COUNT-1:0]   touched;
    logic [SAMPLE_BITS-1:0] best_rd;
    logic [PAD_IDX_W-1:0]   a_idx;
    logic [PAD_IDX_W-1:0]   b_idx;
    logic [PAD_IDX_W-1:0]   nx_idx;
    logic [PAD_IDX_W-1:0]   pv_idx;
    logic [PAD_IDX_W-1:0]   lo_idx;
    logic [PAD_IDX_W-1:0]   hi_idx;
    logic [SAMPLE_BITS-1:0] diff;
    logic                   found;
    logic [POS_W-1:0]       pos;

    always_comb
    begin
        ref_level = '0;
        for (int i = 0; i < PAD_COUNT; i++)
        begin
            if (pad[i] > ref_level)
            begin
                ref_level = pad[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < PAD_COUNT; i++)
        begin
            touched[i] = (SUM_W'(pad[i]) + SUM_W'(touch_threshold)) < SUM_W'(ref_level);
        end
    end

    // largest drop == lowest reading; later pad wins a tie
    always_comb
    begin
        found   = 1'b0;
        a_idx   = '0;
        best_rd = '0;
        for (int i = 0; i < PAD_COUNT; i++)
        begin
            if (touched[i] && (!found || pad[i] <= best_rd))
            begin
                found   = 1'b1;
                a_idx   = PAD_IDX_W'(i);
                best_rd = pad[i];
            end
        end
    end

    assign nx_idx = a_idx + PAD_IDX_W'(1);
    assign pv_idx = a_idx - PAD_IDX_W'(1);

    always_comb
    begin
        if (touched[nx_idx] && touched[pv_idx])
        begin
            b_idx = (pad[nx_idx] < pad[pv_idx]) ? nx_idx : pv_idx;
        end
        else if (touched[nx_idx])
        begin
            b_idx = nx_idx;
        end
        else if (touched[pv_idx])
        begin
            b_idx = pv_idx;
        end
        else
        begin
            b_idx = a_idx;
        end
    end

    assign diff   = (pad[a_idx] > pad[b_idx]) ? (pad[a_idx] - pad[b_idx])
                                              : (pad[b_idx] - pad[a_idx]);
    assign lo_idx = (a_idx < b_idx) ? a_idx : b_idx;
    assign hi_idx = (a_idx < b_idx) ? b_idx : a_idx;

    always_comb
    begin
        pos = {a_idx, 1'b0};
        if ((b_idx != a_idx) && (SUM_W'(diff) < SUM_W'(pair_threshold)))
        begin
            // left/top pair sits between the last and first pad
            if (lo_idx == '0 && hi_idx == PAD_IDX_W'(PAD_COUNT - 1))
            begin
                pos = WRAP_POS;
            end
            else
            begin
                pos = {lo_idx, 1'b1};
            end
        end
    end

    assign hit.found = found;
    assign hit.pos   = found ? pos : '0;

endmodule
